FILE: hw/rtl/oltab_pkg.sv
// Package for the ordered list table engine.
// Holds sizes, request/response structs and the cell control types.
// No dependencies.
package oltab_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int FUNC_W      = 2;
    localparam int POS_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2,
        FN_QUERY  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_func                  func;
        logic [POS_W-1:0]       position;
        logic [VALUE_WIDTH-1:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               hit;
        logic [CNT_W-1:0]   count;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_CMP  = 2'd1,
        OP_INS  = 2'd2,
        OP_DEL  = 2'd3
    } t_cell_op;

    // Broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op               op;
        logic [VALUE_WIDTH-1:0] key;
    } t_cell_ctl;

    // Per-cell position information, decoded at the top level.
    typedef struct packed {
        logic live;       // cell index is below the entry count
        logic at_pos;     // cell index equals the insert position
        logic above_pos;  // cell index is above the insert position
    } t_cell_sel;

endpackage

FILE: hw/rtl/oltab_cell.sv
// One storage cell of the ordered list: holds one entry and its match flag.
// Depends on oltab_pkg. Shifts with its neighbors on insert and remove.
module oltab_cell (
    input  logic                           i_clk,
    input  oltab_pkg::t_cell_ctl           i_ctl,
    input  oltab_pkg::t_cell_sel           i_sel,
    input  logic [oltab_pkg::VALUE_WIDTH-1:0] i_low_val,
    input  logic [oltab_pkg::VALUE_WIDTH-1:0] i_high_val,
    input  logic                           i_seen,
    output logic                           o_seen,
    output logic [oltab_pkg::VALUE_WIDTH-1:0] o_val
);
    import oltab_pkg::*;

    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_match;

    // A match in this cell or any lower one marks the first-match point.
    assign o_seen = i_seen | r_match;
    assign o_val  = r_val;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CMP: begin
                r_match <= i_sel.live && (r_val == i_ctl.key);
            end
            OP_INS: begin
                if (i_sel.at_pos) begin
                    r_val <= i_ctl.key;
                end else if (i_sel.above_pos) begin
                    r_val <= i_low_val;
                end
            end
            OP_DEL: begin
                if (o_seen) begin
                    r_val <= i_high_val;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/ordered_list_table_engine.sv
// Ordered list table engine: a row of entry cells with a small control sequencer.
// Depends on oltab_pkg and oltab_cell.
// A new request is taken only while the sequencer is idle. The cells first register
// their match bits in the compare state; the first-match chain and the shift are then
// resolved in the update state, which waits for the output register to be free.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
module ordered_list_table_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  oltab_pkg::t_req   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output oltab_pkg::t_rsp   o_out_data
);
    import oltab_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_rsp, n_rsp;

    t_cell_ctl              cell_ctl;
    t_cell_sel              cell_sel [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic [DEPTH:0]         seen;
    logic [POS_W-1:0]       ins_pos;
    logic                   found;
    logic                   full;
    logic                   fire;
    logic                   do_ins;
    logic                   do_del;
    t_status                status;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;

    // Append is an insert at the end of the list.
    assign ins_pos = (r_req.func == FN_APPEND) ? POS_W'(r_count) : r_req.position;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign found   = seen[DEPTH];
    assign fire    = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign seen[0] = 1'b0;

    always_comb begin
        status = ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        unique case (r_req.func)
            FN_APPEND: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            FN_INSERT: begin
                if (r_req.position > POS_W'(r_count)) begin
                    status = ST_BAD_POS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (found) begin
                    do_del = 1'b1;
                end else begin
                    status = ST_MISSING;
                end
            end
            FN_QUERY: begin
                if (!found) begin
                    status = ST_MISSING;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cell_ctl.key = r_req.value;
        cell_ctl.op  = OP_NONE;
        if (r_state == S_CMP) begin
            cell_ctl.op = OP_CMP;
        end else if (fire && do_ins) begin
            cell_ctl.op = OP_INS;
        end else if (fire && do_del) begin
            cell_ctl.op = OP_DEL;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            assign cell_sel[k].live      = (CNT_W'(k) < r_count);
            assign cell_sel[k].at_pos    = (POS_W'(k) == ins_pos);
            assign cell_sel[k].above_pos = (POS_W'(k) > ins_pos);

            oltab_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_sel      (cell_sel[k]),
                .i_low_val  ((k == 0) ? r_req.value : cell_val[(k == 0) ? 0 : k-1]),
                .i_high_val (cell_val[(k == DEPTH-1) ? k : k+1]),
                .i_seen     (seen[k]),
                .o_seen     (seen[k+1]),
                .o_val      (cell_val[k])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (fire) begin
                    if (do_ins) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (do_del) begin
                        n_count = r_count - CNT_W'(1);
                    end
                    n_rsp.status = status;
                    n_rsp.hit    = (status == ST_OK);
                    n_rsp.count  = n_count;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds capacity");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rsp.hit == (r_rsp.status == ST_OK)))
        else $error("hit flag disagrees with status");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CMP))
        else $error("accepted request did not start the compare cycle");

    a_count_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && do_del) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not reduce the count by one");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPD) |=> (r_count == $past(r_count)))
        else $error("count changed outside the update cycle");

endmodule
